[hw/rtl/dsfc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsfc_pkg
// Shared types and constants for the DLE stuffed frame checker.
// ----------------------------------------------------------------------------
package dsfc_pkg;

	localparam logic [7:0] SOP_BYTE   = 8'h28;
	localparam logic [7:0] EOP_BYTE   = 8'h29;
	localparam logic [7:0] NL_BYTE    = 8'h0D;
	localparam logic [7:0] DLE_BYTE   = 8'h10;
	localparam logic [7:0] DLE_OFFSET = 8'h80;

	localparam logic [7:0] MIN_LENGTH_RESET = 8'd4;

	// most result words one input word can cause
	localparam int MAX_RESULTS = 3;
	localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

	// result queue
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_INVALID  = 2'd1,
		STATUS_CSUM_ERR = 2'd2
	} dsfc_status_t;

	typedef struct packed {
		logic [7:0] raw_byte;
		logic       end_of_frame;
	} dsfc_in_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       payload_present;
		logic [1:0] frame_status;
		logic       frame_done;
	} dsfc_out_t;

	// words handed from the frame engine to the result queue
	typedef struct packed {
		dsfc_out_t [MAX_RESULTS-1:0] word;
		logic      [RES_CNT_W-1:0]   count;
	} dsfc_push_t;

endpackage

[hw/rtl/dsfc_frame_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsfc_frame_engine
// Per-frame state: raw lookahead, DLE unescaping, held checksum candidate,
// running XOR and delimiter checks. Emits up to three result words per word.
// ----------------------------------------------------------------------------
module dsfc_frame_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  dsfc_pkg::dsfc_in_t item_s1,
	input  logic [7:0]         min_length,
	output dsfc_pkg::dsfc_push_t push
);
	import dsfc_pkg::*;

	typedef struct packed {
		logic [7:0] held;
		logic       held_v;
		logic [7:0] xsum;
		logic       esc;
	} dsfc_acc_t;

	typedef struct packed {
		dsfc_acc_t  acc;
		logic       emit;
		logic [7:0] emit_byte;
	} dsfc_step_t;

	function automatic dsfc_step_t unesc_step(dsfc_acc_t a, logic [7:0] u, logic en);
		dsfc_step_t s;
		s.acc       = a;
		s.emit      = 1'b0;
		s.emit_byte = 8'h00;
		if (en) begin
			if (a.held_v) begin
				s.emit      = 1'b1;
				s.emit_byte = a.held;
				s.acc.xsum  = a.xsum ^ a.held;
			end
			s.acc.held   = u;
			s.acc.held_v = 1'b1;
		end
		return s;
	endfunction

	function automatic dsfc_step_t body_step(dsfc_acc_t a, logic [7:0] b, logic en);
		dsfc_step_t s;
		dsfc_acc_t  t;
		s.acc       = a;
		s.emit      = 1'b0;
		s.emit_byte = 8'h00;
		t           = a;
		if (en) begin
			if (a.esc) begin
				t.esc = 1'b0;
				s = unesc_step(t, b - DLE_OFFSET, 1'b1);
			end else if (b == DLE_BYTE) begin
				s.acc.esc = 1'b1;
			end else begin
				s = unesc_step(a, b, 1'b1);
			end
		end
		return s;
	endfunction

	logic [7:0] la0_q, la1_q;
	logic [1:0] la_cnt_q;
	logic [7:0] raw_cnt_q;
	logic       sok_q;
	dsfc_acc_t  acc_q;

	logic [7:0] la0_d, la1_d;
	logic [1:0] la_cnt_d;
	logic [7:0] raw_cnt_d;
	logic       sok_d;
	dsfc_acc_t  acc_d;

	logic         last, first, nl, ea, eb, er, invalid;
	logic [1:0]   tlen;
	logic [7:0]   eop, n_sat;
	dsfc_step_t   s_a, s_b, s_r;
	dsfc_status_t status;
	logic [2:0]   emit_v;
	logic [7:0]   emit_b [3];
	dsfc_out_t    slots [4];
	logic [1:0]   k;

	always_comb begin
		last  = item_s1.end_of_frame;
		first = (raw_cnt_q == 8'd0);
		nl    = (item_s1.raw_byte == NL_BYTE);
		tlen  = la_cnt_q + {1'b0, !nl};
		if (!nl) begin
			eop = item_s1.raw_byte;
		end else if (la_cnt_q == 2'd2) begin
			eop = la1_q;
		end else begin
			eop = la0_q;
		end

		ea  = !first && (last ? (tlen >= 2'd2) : (la_cnt_q == 2'd2));
		eb  = last && !first && (tlen == 2'd3);
		s_a = body_step(acc_q, la0_q, ea);
		s_b = body_step(s_a.acc, la1_q, eb);
		er  = last && !first && (tlen != 2'd0) && s_b.acc.esc;
		// the closing step only emits when a DLE is left open
		s_r           = s_b;
		s_r.emit      = 1'b0;
		s_r.emit_byte = 8'h00;
		if (er) begin
			s_r.acc.esc = 1'b0;
			s_r = unesc_step(s_r.acc, eop - DLE_OFFSET, 1'b1);
		end

		n_sat   = (raw_cnt_q == 8'd255) ? 8'd255 : raw_cnt_q + 8'd1;
		invalid = first || (n_sat < min_length) || !sok_q || (tlen == 2'd0) ||
		          (eop != EOP_BYTE) || !s_r.acc.held_v;
		if (invalid) begin
			status = STATUS_INVALID;
		end else if (s_r.acc.held != s_r.acc.xsum) begin
			status = STATUS_CSUM_ERR;
		end else begin
			status = STATUS_OK;
		end

		// pack emitted bytes in order, then the frame's final word
		emit_v    = {s_r.emit, s_b.emit, s_a.emit};
		emit_b[0] = s_a.emit_byte;
		emit_b[1] = s_b.emit_byte;
		emit_b[2] = s_r.emit_byte;
		for (int i = 0; i < 4; i++) begin
			slots[i] = '0;
		end
		k = 2'd0;
		for (int i = 0; i < 3; i++) begin
			if (emit_v[i]) begin
				slots[k].payload_byte    = emit_b[i];
				slots[k].payload_present = 1'b1;
				k = k + 2'd1;
			end
		end
		if (last) begin
			slots[k].frame_status = status;
			slots[k].frame_done   = 1'b1;
			k = k + 2'd1;
		end
		for (int i = 0; i < MAX_RESULTS; i++) begin
			push.word[i] = slots[i];
		end
		push.count = fire ? RES_CNT_W'(k) : '0;

		// next frame state
		la0_d     = la0_q;
		la1_d     = la1_q;
		la_cnt_d  = la_cnt_q;
		sok_d     = sok_q;
		acc_d     = s_a.acc;
		raw_cnt_d = n_sat;
		if (last) begin
			la0_d     = '0;
			la1_d     = '0;
			la_cnt_d  = '0;
			sok_d     = 1'b0;
			acc_d     = '0;
			raw_cnt_d = '0;
		end else if (first) begin
			sok_d = (item_s1.raw_byte == SOP_BYTE);
		end else if (la_cnt_q == 2'd2) begin
			la0_d = la1_q;
			la1_d = item_s1.raw_byte;
		end else if (la_cnt_q == 2'd1) begin
			la1_d    = item_s1.raw_byte;
			la_cnt_d = 2'd2;
		end else begin
			la0_d    = item_s1.raw_byte;
			la_cnt_d = 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			la0_q     <= '0;
			la1_q     <= '0;
			la_cnt_q  <= '0;
			raw_cnt_q <= '0;
			sok_q     <= 1'b0;
			acc_q     <= '0;
		end else if (fire) begin
			la0_q     <= la0_d;
			la1_q     <= la1_d;
			la_cnt_q  <= la_cnt_d;
			raw_cnt_q <= raw_cnt_d;
			sok_q     <= sok_d;
			acc_q     <= acc_d;
		end
	end

endmodule

[hw/rtl/dsfc_result_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsfc_result_fifo
// Small result queue: takes up to three words per cycle, gives one.
// ----------------------------------------------------------------------------
module dsfc_result_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dsfc_pkg::dsfc_push_t  push,
	output logic                  room,
	output logic                  result_valid,
	input  logic                  result_ready,
	output dsfc_pkg::dsfc_out_t   result
);
	import dsfc_pkg::*;

	dsfc_out_t             mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic                  pop;

	assign result_valid = (count_q != '0);
	assign result       = mem_q[rd_ptr_q];
	assign pop          = result_valid && result_ready;
	// room for a full burst, without looking at this cycle's pop
	assign room         = (count_q <= FIFO_CNT_W'(FIFO_DEPTH - MAX_RESULTS));

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RESULTS; i++) begin
			if (RES_CNT_W'(i) < push.count) begin
				mem_q[wr_ptr_q + FIFO_PTR_W'(i)] <= push.word[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(push.count);
			rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(pop);
			count_q  <= count_q + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);
		end
	end

endmodule

[hw/rtl/dle_stuffed_frame_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dle_stuffed_frame_checker
// Deframes DLE byte-stuffed frames and checks their XOR checksum.
// ----------------------------------------------------------------------------
// Feed the raw bytes of a frame one word at a time, with end_of_frame set on
// the last one. Each word is registered, then decoded in a single pass into
// at most three result words, which enter a four-entry result queue. A word
// that is not the last of its frame yields at most one payload word; the
// last word yields up to two payload words plus the status word. The block
// takes one word per cycle while the queue holds at most one waiting result,
// so long runs of body bytes flow at one word per cycle; after each frame's
// final word, up to three results drain through the single output port at
// one per cycle while result_ready is high. Payload bytes are emitted
// whatever the final status: the consumer keeps or drops them on the strength
// of frame_status in the frame_done word. min_length must be written through
// cfg_wr_en/cfg_wr_data while the block is idle; it does not enforce this.
// ----------------------------------------------------------------------------
module dle_stuffed_frame_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  dsfc_pkg::dsfc_in_t  item,
	output logic                result_valid,
	input  logic                result_ready,
	output dsfc_pkg::dsfc_out_t result,
	input  logic                cfg_wr_en,
	input  logic [7:0]          cfg_wr_data
);
	import dsfc_pkg::*;

	logic [7:0] min_len_q;
	dsfc_in_t   item_s1;
	logic       valid_s1;
	logic       room;
	logic       fire;
	dsfc_push_t push;

	// decode the registered word once the queue can take a full burst
	assign fire       = valid_s1 && room;
	// refill the input register as soon as its word moves on
	assign item_ready = !valid_s1 || fire;

	// hold min_length; reset gives the standard frame floor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_q <= MIN_LENGTH_RESET;
		end else if (cfg_wr_en) begin
			min_len_q <= cfg_wr_data;
		end
	end

	// input register: valid needs reset, payload does not
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	dsfc_frame_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.item_s1    (item_s1),
		.min_length (min_len_q),
		.push       (push)
	);

	dsfc_result_fifo u_fifo (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.room         (room),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
